@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/rsd_pkg.sv @@
package rsd_pkg;

	localparam int NAME_W = 64;
	localparam int AGE_W  = 8;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// per-cell control from the stack controller
	typedef struct packed {
		logic live;   // cell holds a stored record
		logic load;   // take the pushed record
		logic shift;  // take the record of the neighbor above
	} cell_ctl_t;

endpackage

@@ rtl/rsd_cell.sv @@
module rsd_cell import rsd_pkg::*; #(
	parameter int KEY_BITS = 64
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] key,
	input  logic [AGE_W-1:0]    age,
	input  logic [KEY_BITS-1:0] above_name,
	input  logic [AGE_W-1:0]    above_age,
	output logic [KEY_BITS-1:0] name,
	output logic [AGE_W-1:0]    age_out,
	output logic                match
);

	logic [KEY_BITS-1:0] name_q;
	logic [AGE_W-1:0]    age_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			name_q <= above_name;
			age_q  <= above_age;
		end else if (ctl.load) begin
			name_q <= key;
			age_q  <= age;
		end
	end

	assign match   = ctl.live & (name_q == key);
	assign name    = name_q;
	assign age_out = age_q;

endmodule

@@ rtl/record_stack_with_key_delete_top.sv @@
// A result is presented in the cycle after its item is accepted.
// One item per cycle while the result side takes each result; the key compare in every cell and the
// lowest-match pick over the match vector settle within that cycle.
// Reset (arst_n low, asynchronous): count goes to zero and no result is
// pending; stored records are left as they are and are never read unset.
module record_stack_with_key_delete_top import rsd_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int KEY_BITS    = 64,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	// item side
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        opcode,
	input  logic [NAME_W-1:0] name_key,
	input  logic [AGE_W-1:0]  age_value,
	// result side
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [CW-1:0]     entry_count,
	output logic              top_valid,
	output logic [NAME_W-1:0] top_name,
	output logic [AGE_W-1:0]  top_age
);

	// Control state
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	status_t       status_q;

	// Cell chain wiring; the slot above the top cell reads as zero.
	logic [KEY_BITS-1:0]    chain_name [STACK_DEPTH+1];
	logic [AGE_W-1:0]       chain_age  [STACK_DEPTH+1];
	logic [STACK_DEPTH-1:0] match_vec;
	cell_ctl_t              ctl        [STACK_DEPTH];

	logic                   accept;
	logic [KEY_BITS-1:0]    key;
	opcode_t                op;
	logic                   full;
	logic                   empty;
	logic                   found;
	logic [STACK_DEPTH-1:0] low_match;
	logic [STACK_DEPTH-1:0] below_match;
	logic                   push_go;
	logic                   del_go;
	status_t                status_d;
	logic [CW-1:0]          count_d;
	logic [CW-1:0]          top_idx;

	// The result register frees up when its item is taken, so a new item
	// can enter in the same cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign key   = name_key[KEY_BITS-1:0];
	assign op    = opcode_t'(opcode);
	assign full  = (count_q == CW'(STACK_DEPTH));
	assign empty = (count_q == '0);

	// Lowest matching cell: isolate the lowest set bit, then everything
	// below it keeps its record and everything from it upward shifts down.
	assign found       = |match_vec;
	assign low_match   = match_vec & (~match_vec + 1'b1);
	assign below_match = low_match - 1'b1;

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		push_go  = 1'b0;
		del_go   = 1'b0;
		case (op)
			OP_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					push_go = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			OP_DELETE: begin
				if (!found) begin
					status_d = ST_NOTFOUND;
				end else begin
					del_go  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				// unused opcode: report the current contents
				status_d = ST_DONE;
			end
		endcase
	end

	assign chain_name[STACK_DEPTH] = '0;
	assign chain_age[STACK_DEPTH]  = '0;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		always_comb begin
			ctl[i].live  = (CW'(i) < count_q);
			ctl[i].load  = accept && push_go && (count_q == CW'(i));
			ctl[i].shift = accept && del_go && !below_match[i];
		end

		rsd_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.key       (key),
			.age       (age_value),
			.above_name(chain_name[i+1]),
			.above_age (chain_age[i+1]),
			.name      (chain_name[i]),
			.age_out   (chain_age[i]),
			.match     (match_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// status is payload only, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// The stack contents and count only move on an accepted item, which
	// cannot happen while a result waits, so the top read stays steady.
	assign top_idx     = count_q - 1'b1;
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign top_valid   = !empty;
	assign top_name    = empty ? '0 : NAME_W'(chain_name[top_idx]);
	assign top_age     = empty ? '0 : chain_age[top_idx];

endmodule

@@ rtl/rsd_checker.sv @@
`include "assert_macros.svh"

module rsd_checker import rsd_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [CW-1:0]     entry_count,
	input logic              top_valid,
	input logic [NAME_W-1:0] top_name,
	input logic [AGE_W-1:0]  top_age
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
	`ASSERT_IMPLY(a_top_valid, clk, arst_n, rsp_valid, top_valid == (entry_count != '0))
	`ASSERT_IMPLY(a_empty_top, clk, arst_n, rsp_valid && !top_valid, top_name == '0 && top_age == '0)
	`ASSERT_IMPLY(a_full_cnt, clk, arst_n, rsp_valid && status == ST_FULL, entry_count == CW'(STACK_DEPTH))
	`ASSERT_IMPLY(a_empty_cnt, clk, arst_n, rsp_valid && status == ST_EMPTY, entry_count == '0)

endmodule

bind record_stack_with_key_delete_top rsd_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_rsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.status     (status),
	.entry_count(entry_count),
	.top_valid  (top_valid),
	.top_name   (top_name),
	.top_age    (top_age)
);
